### rtl/core/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared sizes, opcodes, item types and controller/datapath handshake
// structs for the tiny processor step block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpu_pkg;

    // Storage sizes
    localparam int MEM_DEPTH   = 1024;
    localparam int REG_COUNT   = 16;
    localparam int STACK_DEPTH = 16;

    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int STK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_LVL_W = $clog2(STACK_DEPTH + 1);

    // Fixed field widths
    localparam int WORD_W  = 32;
    localparam int FIELD_W = 8;
    localparam int PC_W    = 11;

    // Opcodes
    localparam logic [FIELD_W-1:0] OP_ADD  = 8'h01;
    localparam logic [FIELD_W-1:0] OP_INC  = 8'h05;
    localparam logic [FIELD_W-1:0] OP_CALL = 8'h0E;
    localparam logic [FIELD_W-1:0] OP_RET  = 8'h0F;
    localparam logic [FIELD_W-1:0] OP_LD   = 8'h10;
    localparam logic [FIELD_W-1:0] OP_ST   = 8'h11;

    // Item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Status codes; the halt register holds the same codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  address;
        logic [31:0] data;
        logic [3:0]  reg_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        logic [10:0] program_count;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_CLEAR,
        MEM_LOAD,
        MEM_FETCH,
        MEM_OPERAND,
        MEM_STORE
    } t_mem_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_RREAD,
        S_FETCH,
        S_DECODE,
        S_EXEC,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic    take_in;
        t_mem_op mem_op;
        logic    read_reg;
        logic    decode;
        logic    exec;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic exec_blocked;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/core/tcpu_ctrl.sv
// ----------------------------------------------------------------------------
// tcpu_ctrl
// Sequencer for the tiny processor: memory clear, load, register read and
// the fetch / decode / execute steps of one instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpu_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [1:0]          i_mode,
    input  tcpu_pkg::t_dp_status     i_st,
    output logic                     o_in_stall,
    output tcpu_pkg::t_dp_cmd        o_cmd
);
    import tcpu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_st.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_LOAD: n_state = S_LOAD;
                        MODE_READ: n_state = S_RREAD;
                        MODE_EXEC: n_state = i_st.exec_blocked ? S_RESULT : S_FETCH;
                        default:   n_state = S_RESULT;
                    endcase
                end
            end
            S_LOAD:   n_state = S_RESULT;
            S_RREAD:  n_state = S_RESULT;
            S_FETCH:  n_state = S_DECODE;
            S_DECODE: n_state = S_EXEC;
            S_EXEC:   n_state = S_RESULT;
            S_RESULT: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR:  o_cmd.mem_op = MEM_CLEAR;
            S_IDLE:   o_cmd.take_in = i_in_valid;
            S_LOAD:   o_cmd.mem_op = MEM_LOAD;
            S_RREAD:  o_cmd.read_reg = 1'b1;
            S_FETCH:  o_cmd.mem_op = MEM_FETCH;
            S_DECODE: begin
                o_cmd.mem_op = MEM_OPERAND;
                o_cmd.decode = 1'b1;
            end
            S_EXEC: begin
                o_cmd.mem_op = MEM_STORE;
                o_cmd.exec   = 1'b1;
            end
            S_RESULT: o_cmd.load_out = i_st.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/tcpu_dp.sv
// ----------------------------------------------------------------------------
// tcpu_dp
// Datapath of the tiny processor: word memory, register file, return stack,
// program counter, halt code and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpu_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  tcpu_pkg::t_dp_cmd      i_cmd,
    input  tcpu_pkg::t_in_item     i_in_item,
    input  wire logic              i_out_stall,
    output tcpu_pkg::t_dp_status   o_st,
    output logic                   o_out_valid,
    output tcpu_pkg::t_out_item    o_out_item
);
    import tcpu_pkg::*;

    // Word memory, single port, registered read
    logic [WORD_W-1:0]    r_mem [MEM_DEPTH];
    logic [WORD_W-1:0]    r_mem_q;
    logic                 r_mem_ok;
    logic [MEM_AW-1:0]    r_clr_cnt;
    logic [31:0]          mem_addr;
    logic [MEM_AW-1:0]    mem_idx;
    logic                 mem_ok;
    logic                 mem_we;
    logic                 mem_re;
    logic [WORD_W-1:0]    mem_wd;
    logic [WORD_W-1:0]    mem_rdata;

    // Register file, two registered read ports, one write port
    logic [WORD_W-1:0]    r_regs [REG_COUNT];
    logic [REG_COUNT-1:0] r_reg_vld;
    logic [WORD_W-1:0]    r_rd_a, r_rd_b;
    logic                 r_rd_a_ok, r_rd_b_ok;
    logic [FIELD_W-1:0]   rd_a_sel;
    logic [REG_IDX_W-1:0] rd_a_idx, rd_b_idx, wr_idx;
    logic                 rd_a_ok, rd_b_ok, wr_ok;
    logic                 rd_a_en;
    logic [WORD_W-1:0]    val_a, val_b;
    logic                 reg_we;
    logic [WORD_W-1:0]    reg_wd;

    // Control state
    t_in_item             r_item;
    logic [2*FIELD_W-1:0] r_ir;
    logic [PC_W-1:0]      r_pc, n_pc;
    logic [PC_W-1:0]      pc_inc;
    logic [STK_LVL_W-1:0] r_lvl, n_lvl;
    logic [STK_LVL_W-1:0] lvl_m1;
    logic [1:0]           r_halt, n_halt;
    logic [PC_W-1:0]      r_stack [STACK_DEPTH];
    logic                 stk_we;

    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic [1:0]           status;

    // Instruction fields: decode from fresh fetch data, execute from IR
    logic [FIELD_W-1:0] dec_op, dec_a, dec_b, dec_c;
    logic [FIELD_W-1:0] exe_op, exe_a;

    assign mem_rdata = r_mem_ok ? r_mem_q : '0;
    assign dec_op    = mem_rdata[31:24];
    assign dec_a     = mem_rdata[23:16];
    assign dec_b     = mem_rdata[15:8];
    assign dec_c     = mem_rdata[7:0];
    assign exe_op    = r_ir[2*FIELD_W-1:FIELD_W];
    assign exe_a     = r_ir[FIELD_W-1:0];

    // ---------------- memory port ----------------
    always_comb begin
        mem_addr = '0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_wd   = '0;
        case (i_cmd.mem_op)
            MEM_CLEAR: begin
                mem_addr = 32'(r_clr_cnt);
                mem_we   = 1'b1;
            end
            MEM_LOAD: begin
                mem_addr = 32'(r_item.address);
                mem_we   = 1'b1;
                mem_wd   = r_item.data;
            end
            MEM_FETCH: begin
                mem_addr = 32'(r_pc);
                mem_re   = 1'b1;
            end
            MEM_OPERAND: begin
                mem_addr = 32'(dec_b);
                mem_re   = 1'b1;
            end
            MEM_STORE: begin
                mem_addr = 32'(exe_a);
                mem_we   = (exe_op == OP_ST);
                mem_wd   = val_a;
            end
            default: mem_addr = '0;
        endcase
    end

    assign mem_ok  = (mem_addr < 32'(MEM_DEPTH));
    assign mem_idx = mem_addr[MEM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we && mem_ok) r_mem[mem_idx] <= mem_wd;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mem_q  <= r_mem[mem_idx];
            r_mem_ok <= mem_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.mem_op == MEM_CLEAR) begin
            r_clr_cnt <= r_clr_cnt + MEM_AW'(1);
        end
    end

    // ---------------- register file ----------------
    assign rd_a_sel = i_cmd.read_reg ? FIELD_W'(r_item.reg_index)
                                     : ((dec_op == OP_INC) ? dec_a : dec_b);
    assign rd_a_en  = i_cmd.read_reg || i_cmd.decode;
    assign rd_a_ok  = (32'(rd_a_sel) < 32'(REG_COUNT));
    assign rd_b_ok  = (32'(dec_c) < 32'(REG_COUNT));
    assign wr_ok    = (32'(exe_a) < 32'(REG_COUNT));
    assign rd_a_idx = rd_a_sel[REG_IDX_W-1:0];
    assign rd_b_idx = dec_c[REG_IDX_W-1:0];
    assign wr_idx   = exe_a[REG_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (rd_a_en) begin
            r_rd_a    <= r_regs[rd_a_idx];
            r_rd_a_ok <= rd_a_ok && r_reg_vld[rd_a_idx];
        end
        if (i_cmd.decode) begin
            r_rd_b    <= r_regs[rd_b_idx];
            r_rd_b_ok <= rd_b_ok && r_reg_vld[rd_b_idx];
        end
    end

    assign val_a = r_rd_a_ok ? r_rd_a : '0;
    assign val_b = r_rd_b_ok ? r_rd_b : '0;

    always_comb begin
        reg_we = 1'b0;
        reg_wd = '0;
        case (exe_op)
            OP_ADD: begin
                reg_we = 1'b1;
                reg_wd = val_a + val_b;
            end
            OP_INC: begin
                reg_we = 1'b1;
                reg_wd = val_a + WORD_W'(1);
            end
            OP_LD: begin
                reg_we = 1'b1;
                reg_wd = mem_rdata;
            end
            default: reg_we = 1'b0;
        endcase
        reg_we = reg_we && i_cmd.exec && wr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) r_regs[wr_idx] <= reg_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
        end else if (reg_we) begin
            r_reg_vld[wr_idx] <= 1'b1;
        end
    end

    // ---------------- program flow ----------------
    assign pc_inc = r_pc + PC_W'(1);
    assign lvl_m1 = r_lvl - STK_LVL_W'(1);

    always_comb begin
        n_pc   = r_pc;
        n_lvl  = r_lvl;
        n_halt = r_halt;
        stk_we = 1'b0;
        if (i_cmd.decode) begin
            n_pc = pc_inc;
            case (dec_op)
                OP_CALL: begin
                    if (r_lvl >= STK_LVL_W'(STACK_DEPTH)) begin
                        n_halt = ST_OVERFLOW;
                    end else begin
                        stk_we = 1'b1;
                        n_lvl  = r_lvl + STK_LVL_W'(1);
                        n_pc   = PC_W'(dec_a);
                    end
                end
                OP_RET: begin
                    if (r_lvl != '0) begin
                        n_lvl = lvl_m1;
                        n_pc  = r_stack[lvl_m1[STK_IDX_W-1:0]];
                    end
                end
                OP_ADD, OP_INC, OP_LD, OP_ST: n_halt = r_halt;
                default: n_halt = ST_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_lvl  <= '0;
            r_halt <= ST_OK;
        end else begin
            r_pc   <= n_pc;
            r_lvl  <= n_lvl;
            r_halt <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stack[r_lvl[STK_IDX_W-1:0]] <= pc_inc;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) r_item <= i_in_item;
        if (i_cmd.decode)  r_ir   <= mem_rdata[31:16];
    end

    // ---------------- result ----------------
    always_comb begin
        if (r_halt != ST_OK) begin
            status = r_halt;
        end else if (32'(r_pc) >= 32'(MEM_DEPTH)) begin
            status = ST_DONE;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.read_value    <= (r_item.mode == MODE_READ) ? val_a : '0;
            r_out_item.program_count <= r_pc;
            r_out_item.status        <= status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;
    assign o_st.clear_last   = (r_clr_cnt == MEM_AW'(MEM_DEPTH - 1));
    assign o_st.exec_blocked = (r_halt != ST_OK) || (32'(r_pc) >= 32'(MEM_DEPTH));
    assign o_st.out_free     = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

### rtl/core/tiny_cpu_step.sv
// Sequence, accept to result in the output register: an unused mode or a
//   blocked execute goes straight to the result step, a memory load or
//   register read passes its load or read step first, and an executed
//   instruction runs fetch, decode and execute on the one memory port.
// Items: the sequencer takes no new item until the current one is in the
//   output register; the next item may be taken while that result waits to be taken.
// Reset: synchronous, active low; then a memory clear, no item taken.
// ----------------------------------------------------------------------------
// tiny_cpu_step
// Top level of the tiny processor step block: sequencer plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_cpu_step (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  tcpu_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output tcpu_pkg::t_out_item   o_out_item
);
    import tcpu_pkg::*;

    // Commands flow from the sequencer to the datapath; status flows back.
    t_dp_cmd    cmd;
    t_dp_status dp_st;

    // Sequencer: after reset it sweeps the memory to zero, then sits idle
    // until an item arrives. The mode picks the path:
    //   load     - write one memory word
    //   read     - read one register through port A
    //   execute  - fetch at pc, decode (pc, stack, halt, register reads and
    //              the operand read for LD), then write back or store
    // Every path ends in the result step, which holds until the output
    // register is free.
    tcpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_item.mode),
        .i_st       (dp_st),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Datapath: owns all architectural state and the output register.
    tcpu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_st        (dp_st),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // A fetch is always followed by its decode step.
    a_fetch_then_decode: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mem_op == MEM_FETCH) |=> cmd.decode
    ) else $error("fetch not followed by decode");

    // A result is only loaded when the output register can take it.
    a_load_when_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> dp_st.out_free
    ) else $error("result loaded over a pending item");

    // No item enters while the memory clear is running.
    a_no_take_in_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mem_op == MEM_CLEAR) |-> (o_in_stall && !cmd.take_in)
    ) else $error("item accepted during memory clear");
`endif

endmodule

`default_nettype wire
